### hdl/chte_pkg.sv
// Package for the chained hash table engine: field widths, operation and
// status codes, controller states and the command/status structs.
// No dependencies.
package chte_pkg;

	localparam int unsigned KEY_W     = 16;
	localparam int unsigned NAME_W    = 40;
	localparam int unsigned VALUE_W   = 32;
	localparam int unsigned DATA_W    = KEY_W + NAME_W + VALUE_W;
	localparam int unsigned OP_W      = 2;
	localparam int unsigned STATUS_W  = 2;
	localparam int unsigned SLOT_W    = 6;
	localparam int unsigned COUNT_W   = 6;
	// bucket remainder: reciprocal multiply, then multiply back and subtract
	localparam int unsigned MOD_STEPS = 2;
	localparam int unsigned MOD_CNT_W = $clog2(MOD_STEPS);

	// operation codes; the fourth code is a no-op answered as not found
	localparam logic [OP_W-1:0] OP_SEARCH = 2'd0;
	localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
	localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd1;
	localparam logic [STATUS_W-1:0] ST_DUP      = 2'd2;
	localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

	localparam logic [SLOT_W-1:0] SLOT_NONE = 6'h3F;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_DISPATCH,
		S_MOD,
		S_HEAD,
		S_HEAD_WAIT,
		S_WALK,
		S_INS_POP,
		S_INS_W1,
		S_INS_W2,
		S_DEL_W1,
		S_DEL_W2,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic clr_step;
		logic load;
		logic mod_step;
		logic head_rd;
		logic walk_start;
		logic walk_step;
		logic pop_rd;
		logic ins_w1;
		logic ins_w2;
		logic del_w1;
		logic del_w2;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic            clr_last;
		logic            mod_last;
		logic [OP_W-1:0] op;
		logic            full;
		logic            head_valid;
		logic            walk_hit;
		logic            walk_more;
		logic            out_busy;
	} sts_t;

endpackage

### hdl/chte_ram.sv
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
module chte_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### hdl/chte_ctrl.sv
// Controller state machine of the chained hash table engine.
// Depends on chte_pkg; drives commands into chte_dp and reads its status.
module chte_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  chte_pkg::sts_t sts,
	output chte_pkg::cmd_t cmd
);

	import chte_pkg::*;

	state_t state_q;
	state_t state_next;
	state_t miss_next;
	state_t hit_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_next;
		end
	end

	// where to go once the chain walk has settled
	always_comb begin
		miss_next = (sts.op == OP_INSERT) ? S_INS_POP : S_FINISH;
		hit_next  = (sts.op == OP_DELETE) ? S_DEL_W1 : S_FINISH;
	end

	always_comb begin
		state_next = state_q;
		case (state_q)
			S_CLEAR: begin
				if (sts.clr_last) state_next = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) state_next = S_DISPATCH;
			end
			S_DISPATCH: begin
				if (sts.op != OP_SEARCH && sts.op != OP_INSERT && sts.op != OP_DELETE) begin
					state_next = S_FINISH;
				end else if (sts.op == OP_INSERT && sts.full) begin
					state_next = S_FINISH;
				end else begin
					state_next = S_MOD;
				end
			end
			S_MOD: begin
				if (sts.mod_last) state_next = S_HEAD;
			end
			S_HEAD: begin
				state_next = S_HEAD_WAIT;
			end
			S_HEAD_WAIT: begin
				state_next = sts.head_valid ? S_WALK : miss_next;
			end
			S_WALK: begin
				if (sts.walk_hit) begin
					state_next = hit_next;
				end else if (!sts.walk_more) begin
					state_next = miss_next;
				end
			end
			S_INS_POP: begin
				state_next = S_INS_W1;
			end
			S_INS_W1: begin
				state_next = S_INS_W2;
			end
			S_INS_W2: begin
				state_next = S_FINISH;
			end
			S_DEL_W1: begin
				state_next = S_DEL_W2;
			end
			S_DEL_W2: begin
				state_next = S_FINISH;
			end
			S_FINISH: begin
				if (!sts.out_busy) state_next = S_IDLE;
			end
			default: begin
				state_next = S_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_stall = (state_q != S_IDLE);
		case (state_q)
			S_CLEAR:     cmd.clr_step   = 1'b1;
			S_IDLE:      cmd.load       = in_valid;
			S_MOD:       cmd.mod_step   = 1'b1;
			S_HEAD:      cmd.head_rd    = 1'b1;
			S_HEAD_WAIT: cmd.walk_start = sts.head_valid;
			S_WALK:      cmd.walk_step  = 1'b1;
			S_INS_POP:   cmd.pop_rd     = 1'b1;
			S_INS_W1:    cmd.ins_w1     = 1'b1;
			S_INS_W2:    cmd.ins_w2     = 1'b1;
			S_DEL_W1:    cmd.del_w1     = 1'b1;
			S_DEL_W2:    cmd.del_w2     = 1'b1;
			S_FINISH:    cmd.finish     = !sts.out_busy;
			default:     cmd            = '0;
		endcase
	end

endmodule

### hdl/chte_dp.sv
// Datapath of the chained hash table engine: bucket remainder unit, chain
// walk registers, free stack, head/link/record RAMs and the result register.
// Depends on chte_pkg and chte_ram.
module chte_dp #(
	parameter int unsigned BUCKETS = 31,
	parameter int unsigned ENTRIES = 32
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  chte_pkg::cmd_t                         cmd,
	output chte_pkg::sts_t                         sts,
	input  logic [chte_pkg::OP_W-1:0]              op,
	input  logic [chte_pkg::KEY_W-1:0]             key,
	input  logic [chte_pkg::NAME_W-1:0]            name_chars,
	input  logic signed [chte_pkg::VALUE_W-1:0]    value,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic [chte_pkg::STATUS_W-1:0]          status,
	output logic [chte_pkg::SLOT_W-1:0]            slot,
	output logic [chte_pkg::SLOT_W-1:0]            previous_slot,
	output logic [chte_pkg::NAME_W-1:0]            found_name,
	output logic signed [chte_pkg::VALUE_W-1:0]    found_value,
	output logic [chte_pkg::COUNT_W-1:0]           entry_count,
	output logic [$clog2(ENTRIES+1)-1:0]           occupied
);

	import chte_pkg::*;

	localparam int unsigned BW    = $clog2(BUCKETS);
	localparam int unsigned AW    = $clog2(ENTRIES);
	localparam int unsigned IW    = AW + 1;
	localparam int unsigned NW    = $clog2(ENTRIES + 1);
	localparam int unsigned CLR_N = (BUCKETS > ENTRIES) ? BUCKETS : ENTRIES;
	localparam int unsigned CLW   = $clog2(CLR_N);
	localparam logic [IW-1:0] NONE = '1;
	// key / BUCKETS as (key * RECIP) >> RS, exact for every 16-bit key
	localparam int unsigned RS    = KEY_W + BW;
	localparam int unsigned PW    = 2 * KEY_W + 1;
	localparam logic [KEY_W:0] RECIP =
		(KEY_W+1)'(((64'd1 << RS) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS));

	function automatic logic idx_ok(input logic [IW-1:0] idx);
		return idx < IW'(ENTRIES);
	endfunction

	function automatic logic [SLOT_W-1:0] to_slot(input logic [IW-1:0] idx);
		logic [31:0] w;
		w = 32'(idx);
		return idx_ok(idx) ? w[SLOT_W-1:0] : SLOT_NONE;
	endfunction

	// item registers
	logic [OP_W-1:0]    op_q;
	logic [KEY_W-1:0]   key_q;
	logic [NAME_W-1:0]  name_q;
	logic [VALUE_W-1:0] value_q;
	logic               full_q;

	// remainder unit
	logic [MOD_CNT_W-1:0] mod_cnt_q;
	logic [BW-1:0]        rem_q;
	logic [KEY_W-1:0]     quot_q;
	logic [PW-1:0]        rprod;
	logic [KEY_W-1:0]     qmul;
	logic [KEY_W-1:0]     rem_full;

	// walk and update registers
	logic [IW-1:0]      cur_q;
	logic [IW-1:0]      prev_q;
	logic [NW-1:0]      steps_q;
	logic               hit_valid_q;
	logic [IW-1:0]      hit_q;
	logic [IW-1:0]      hit_link_q;
	logic [IW-1:0]      last_link_q;
	logic [NAME_W-1:0]  hit_name_q;
	logic [VALUE_W-1:0] hit_value_q;
	logic [IW-1:0]      new_q;
	logic [IW-1:0]      free_top_q;
	logic [NW-1:0]      count_q;
	logic [CLW-1:0]     clr_q;
	logic               prev_ok;

	// RAM ports
	logic              head_we;
	logic [BW-1:0]     head_waddr;
	logic [IW-1:0]     head_wdata;
	logic [IW-1:0]     head_rdata;
	logic              link_we;
	logic [AW-1:0]     link_waddr;
	logic [IW-1:0]     link_wdata;
	logic [IW-1:0]     link_rdata;
	logic [IW-1:0]     link_widx;
	logic              ent_re;
	logic [IW-1:0]     ent_ridx;
	logic [DATA_W-1:0] data_rdata;
	logic [KEY_W-1:0]  rd_key;
	logic [NAME_W-1:0] rd_name;
	logic [VALUE_W-1:0] rd_value;
	logic              clr_in_b;
	logic              clr_in_e;
	logic [IW-1:0]     clr_link;

	// result register
	logic                out_valid_q;
	logic [STATUS_W-1:0] res_status;
	logic [SLOT_W-1:0]   res_slot;
	logic [SLOT_W-1:0]   res_prev;
	logic [NAME_W-1:0]   res_name;
	logic [VALUE_W-1:0]  res_value;
	logic [31:0]         count_wide;

	assign {rd_key, rd_name, rd_value} = data_rdata;
	assign prev_ok = idx_ok(prev_q);

	// first step: quotient by reciprocal multiply; second: multiply back, subtract
	assign rprod    = PW'(key_q) * PW'(RECIP);
	assign qmul     = quot_q * KEY_W'(BUCKETS);
	assign rem_full = key_q - qmul;

	assign clr_in_b = 32'(clr_q) < BUCKETS;
	assign clr_in_e = 32'(clr_q) < ENTRIES;
	assign clr_link = (32'(clr_q) + 32'd1 < ENTRIES) ? IW'(32'(clr_q) + 32'd1) : NONE;

	always_comb begin
		sts            = '0;
		sts.clr_last   = clr_q == CLW'(CLR_N - 1);
		sts.mod_last   = mod_cnt_q == MOD_CNT_W'(MOD_STEPS - 1);
		sts.op         = op_q;
		sts.full       = full_q;
		sts.head_valid = idx_ok(head_rdata);
		sts.walk_hit   = rd_key == key_q;
		sts.walk_more  = idx_ok(link_rdata) && (steps_q + 1'b1 < NW'(ENTRIES));
		sts.out_busy   = out_valid_q && out_stall;
	end

	// head RAM write port
	always_comb begin
		head_we    = (cmd.clr_step && clr_in_b)
		          || ((cmd.ins_w1 || cmd.del_w1) && !prev_ok);
		head_waddr = cmd.clr_step ? clr_q[BW-1:0] : rem_q;
		if (cmd.clr_step) begin
			head_wdata = NONE;
		end else if (cmd.ins_w1) begin
			head_wdata = new_q;
		end else begin
			head_wdata = hit_link_q;
		end
	end

	// link RAM write port
	always_comb begin
		link_we = (cmd.clr_step && clr_in_e) || cmd.ins_w1
		       || ((cmd.ins_w2 || cmd.del_w1) && prev_ok) || cmd.del_w2;
		link_widx  = hit_q;
		link_wdata = free_top_q;
		if (cmd.ins_w1) begin
			link_widx  = new_q;
			link_wdata = prev_ok ? last_link_q : NONE;
		end else if (cmd.ins_w2) begin
			link_widx  = prev_q;
			link_wdata = new_q;
		end else if (cmd.del_w1) begin
			link_widx  = prev_q;
			link_wdata = hit_link_q;
		end else if (cmd.clr_step) begin
			link_wdata = clr_link;
		end
		link_waddr = cmd.clr_step ? clr_q[AW-1:0] : link_widx[AW-1:0];
	end

	// shared read address of the link and record RAMs
	always_comb begin
		ent_re = cmd.walk_start || cmd.walk_step || cmd.pop_rd;
		if (cmd.walk_start) begin
			ent_ridx = head_rdata;
		end else if (cmd.walk_step) begin
			ent_ridx = link_rdata;
		end else begin
			ent_ridx = free_top_q;
		end
	end

	chte_ram #(.WIDTH(IW), .DEPTH(BUCKETS)) u_head_ram (
		.clk   (clk),
		.we    (head_we),
		.waddr (head_waddr),
		.wdata (head_wdata),
		.re    (cmd.head_rd),
		.raddr (rem_q),
		.rdata (head_rdata)
	);

	chte_ram #(.WIDTH(IW), .DEPTH(ENTRIES)) u_link_ram (
		.clk   (clk),
		.we    (link_we),
		.waddr (link_waddr),
		.wdata (link_wdata),
		.re    (ent_re),
		.raddr (ent_ridx[AW-1:0]),
		.rdata (link_rdata)
	);

	chte_ram #(.WIDTH(DATA_W), .DEPTH(ENTRIES)) u_data_ram (
		.clk   (clk),
		.we    (cmd.ins_w1),
		.waddr (new_q[AW-1:0]),
		.wdata ({key_q, name_q, value_q}),
		.re    (ent_re),
		.raddr (ent_ridx[AW-1:0]),
		.rdata (data_rdata)
	);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			free_top_q  <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clr_step) clr_q <= clr_q + 1'b1;
			if (cmd.ins_w1) free_top_q <= link_rdata;
			if (cmd.del_w2) free_top_q <= hit_q;
			if (cmd.ins_w2) count_q <= count_q + 1'b1;
			if (cmd.del_w2 && count_q != '0) count_q <= count_q - 1'b1;
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q        <= op;
			key_q       <= key;
			name_q      <= name_chars;
			value_q     <= value;
			full_q      <= (count_q >= NW'(ENTRIES)) || !idx_ok(free_top_q);
			mod_cnt_q   <= '0;
			rem_q       <= '0;
			prev_q      <= NONE;
			hit_valid_q <= 1'b0;
		end
		if (cmd.mod_step) begin
			mod_cnt_q <= mod_cnt_q + 1'b1;
			quot_q    <= KEY_W'(rprod >> RS);
			rem_q     <= rem_full[BW-1:0];
		end
		if (cmd.walk_start) begin
			cur_q   <= head_rdata;
			steps_q <= '0;
		end
		if (cmd.walk_step) begin
			if (sts.walk_hit) begin
				hit_valid_q <= 1'b1;
				hit_q       <= cur_q;
				hit_link_q  <= link_rdata;
				hit_name_q  <= rd_name;
				hit_value_q <= rd_value;
			end else begin
				prev_q      <= cur_q;
				cur_q       <= link_rdata;
				last_link_q <= link_rdata;
				steps_q     <= steps_q + 1'b1;
			end
		end
		if (cmd.pop_rd) new_q <= free_top_q;
		if (cmd.finish) begin
			status        <= res_status;
			slot          <= res_slot;
			previous_slot <= res_prev;
			found_name    <= res_name;
			found_value   <= res_value;
			entry_count   <= count_wide[COUNT_W-1:0];
		end
	end

	assign count_wide = 32'(count_q);

	always_comb begin
		res_status = ST_NOTFOUND;
		res_slot   = SLOT_NONE;
		res_prev   = SLOT_NONE;
		res_name   = '0;
		res_value  = '0;
		if (op_q != OP_SEARCH && op_q != OP_INSERT && op_q != OP_DELETE) begin
			res_status = ST_NOTFOUND;
		end else if (op_q == OP_INSERT && full_q) begin
			res_status = ST_FULL;
		end else if (hit_valid_q) begin
			res_status = (op_q == OP_INSERT) ? ST_DUP : ST_OK;
			res_slot   = to_slot(hit_q);
			res_prev   = to_slot(prev_q);
			if (op_q == OP_SEARCH) begin
				res_name  = hit_name_q;
				res_value = hit_value_q;
			end
		end else if (op_q == OP_INSERT) begin
			res_status = ST_OK;
			res_slot   = to_slot(new_q);
			res_prev   = to_slot(prev_q);
		end else begin
			res_prev = to_slot(prev_q);
		end
	end

	assign out_valid = out_valid_q;
	assign occupied  = count_q;

endmodule

### hdl/chained_hash_table_engine_top.sv
// Top level of the chained hash table engine.
// Depends on chte_pkg, chte_ctrl, chte_dp (which uses chte_ram).
//
// The engine keeps ENTRIES records (key, five name bytes, signed value) in
// BUCKETS chains; a key's bucket is key modulo BUCKETS, and unused records
// sit on a free stack. Each input item is a search, insert or delete and
// yields exactly one result item. Items are handled one at a time: in_stall
// is low only while the engine is idle. An item passes through a dispatch
// step, the bucket remainder unit (a reciprocal multiply for the quotient,
// then multiply back and subtract), the bucket head read, the chain walk
// (one registered read of the link and record RAMs per record visited), the
// free stack pop and link updates of an insert or the unlink and push of a
// delete, and the result load. An insert into a full table and the unused
// op code skip the walk. A result waits in the output register until taken;
// the engine holds its finished result back while the previous one is still
// stalled. The next item is accepted in the idle state that follows the
// result load. After reset the engine runs a clearing pass over max(BUCKETS,
// ENTRIES) addresses to empty the bucket heads and thread the free stack,
// with in_stall held high.
module chained_hash_table_engine_top #(
	parameter int unsigned BUCKETS = 31,
	parameter int unsigned ENTRIES = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [chte_pkg::OP_W-1:0]           op,
	input  logic [chte_pkg::KEY_W-1:0]          key,
	input  logic [chte_pkg::NAME_W-1:0]         name_chars,
	input  logic signed [chte_pkg::VALUE_W-1:0] value,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [chte_pkg::STATUS_W-1:0]       status,
	output logic [chte_pkg::SLOT_W-1:0]         slot,
	output logic [chte_pkg::SLOT_W-1:0]         previous_slot,
	output logic [chte_pkg::NAME_W-1:0]         found_name,
	output logic signed [chte_pkg::VALUE_W-1:0] found_value,
	output logic [chte_pkg::COUNT_W-1:0]        entry_count
);

	import chte_pkg::*;

	cmd_t cmd;
	sts_t sts;
	logic [$clog2(ENTRIES+1)-1:0] occupied;

	// sequencer: walks the item through remainder, walk and update steps
	chte_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// storage, walk registers and result register
	chte_dp #(.BUCKETS(BUCKETS), .ENTRIES(ENTRIES)) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.op            (op),
		.key           (key),
		.name_chars    (name_chars),
		.value         (value),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.status        (status),
		.slot          (slot),
		.previous_slot (previous_slot),
		.found_name    (found_name),
		.found_value   (found_value),
		.entry_count   (entry_count),
		.occupied      (occupied)
	);

	// the occupancy counter never runs past the table size
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(occupied) <= ENTRIES)
		else $error("occupied count exceeds table size");

	// a new result appears only after the controller loaded one
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(cmd.finish))
		else $error("result raised without a finish command");

	// once an item is taken the engine holds off further items
	a_busy_after_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> in_stall)
		else $error("engine not busy after accepting an item");

	// a full-table answer names no record
	a_full_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_FULL) |-> (slot == SLOT_NONE && previous_slot == SLOT_NONE))
		else $error("full result carries a slot");

endmodule
